// ===== src/iacc_pkg.sv =====
package iacc_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int MODE_W         = 3;
  localparam int OPERAND_W      = 32;
  localparam int VALUE_W        = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 3'd0,
    MODE_SUB    = 3'd1,
    MODE_MUL    = 3'd2,
    MODE_DIV    = 3'd3,
    MODE_SQUARE = 3'd4,
    MODE_SQRT   = 3'd5,
    MODE_LOAD   = 3'd6
  } iacc_mode_t;

  typedef struct packed {
    logic [MODE_W-1:0]           mode;
    logic signed [OPERAND_W-1:0] operand;
  } iacc_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      divide_by_zero;
  } iacc_out_t;

  // operations of the serial unit
  typedef enum logic [1:0] {
    UOP_MUL  = 2'd0,
    UOP_DIV  = 2'd1,
    UOP_SQRT = 2'd2
  } iacc_uop_t;

  typedef struct packed {
    logic      start;
    iacc_uop_t op;
  } iacc_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iacc_sts_t;

endpackage

// ===== src/iacc_serial_unit.sv =====
module iacc_serial_unit import iacc_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  iacc_cmd_t             cmd,
  input  logic [DATA_WIDTH-1:0] a,
  input  logic [DATA_WIDTH-1:0] b,
  output iacc_sts_t             sts,
  output logic [DATA_WIDTH-1:0] result
);

  localparam int CNT_W  = $clog2(DATA_WIDTH + 1);
  localparam int SQ_TOP = ((DATA_WIDTH - 2) / 2) * 2;

  typedef enum logic [4:0] {
    U_IDLE = 5'b00001,
    U_MUL  = 5'b00010,
    U_DIV  = 5'b00100,
    U_SQRT = 5'b01000,
    U_FIX  = 5'b10000
  } ustate_t;

  ustate_t               state_r, state_nxt;
  iacc_uop_t             op_r, op_nxt;
  logic [DATA_WIDTH-1:0] a_r, a_nxt;
  logic [DATA_WIDTH-1:0] b_r, b_nxt;
  logic [DATA_WIDTH-1:0] p_r, p_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  neg_r, neg_nxt;
  logic                  done_r, done_nxt;
  logic [DATA_WIDTH-1:0] result_r, result_nxt;

  logic [DATA_WIDTH-1:0] mag_a, mag_b;
  logic [DATA_WIDTH-1:0] trial;
  logic [DATA_WIDTH:0]   sq_sum, sq_next_root;

  assign mag_a = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
  assign mag_b = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;

  // divide: remainder picks up the next dividend bit
  assign trial = {p_r[DATA_WIDTH-2:0], a_r[DATA_WIDTH-1]};

  // square root: root + bit, and root + 2*bit
  assign sq_sum       = {1'b0, a_r} + {1'b0, b_r};
  assign sq_next_root = {1'b0, a_r} + {b_r, 1'b0};

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    p_nxt      = p_r;
    cnt_nxt    = cnt_r;
    neg_nxt    = neg_r;
    done_nxt   = 1'b0;
    result_nxt = result_r;
    case (state_r)
      U_IDLE: begin
        if (cmd.start) begin
          op_nxt  = cmd.op;
          cnt_nxt = CNT_W'(DATA_WIDTH);
          case (cmd.op)
            UOP_MUL: begin
              a_nxt     = a;
              b_nxt     = b;
              p_nxt     = '0;
              state_nxt = U_MUL;
            end
            UOP_DIV: begin
              a_nxt     = mag_a;
              b_nxt     = mag_b;
              p_nxt     = '0;
              neg_nxt   = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
              state_nxt = U_DIV;
            end
            default: begin
              p_nxt     = mag_a;
              a_nxt     = '0;
              b_nxt     = DATA_WIDTH'(1) << SQ_TOP;
              state_nxt = U_SQRT;
            end
          endcase
        end
      end
      U_MUL: begin
        if (b_r[0]) begin
          p_nxt = p_r + a_r;
        end
        a_nxt   = a_r << 1;
        b_nxt   = b_r >> 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = U_FIX;
        end
      end
      U_DIV: begin
        if (trial >= b_r) begin
          p_nxt = trial - b_r;
          a_nxt = {a_r[DATA_WIDTH-2:0], 1'b1};
        end else begin
          p_nxt = trial;
          a_nxt = {a_r[DATA_WIDTH-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = U_FIX;
        end
      end
      U_SQRT: begin
        if ({1'b0, p_r} >= sq_sum) begin
          p_nxt = p_r - sq_sum[DATA_WIDTH-1:0];
          a_nxt = sq_next_root[DATA_WIDTH:1];
        end else begin
          a_nxt = a_r >> 1;
        end
        b_nxt = b_r >> 2;
        if ((b_r >> 2) == '0) begin
          state_nxt = U_FIX;
        end
      end
      U_FIX: begin
        case (op_r)
          UOP_MUL: result_nxt = p_r;
          UOP_DIV: result_nxt = neg_r ? (~a_r + 1'b1) : a_r;
          default: result_nxt = (p_r > a_r) ? (a_r + 1'b1) : a_r;
        endcase
        done_nxt  = 1'b1;
        state_nxt = U_IDLE;
      end
      default: state_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    op_r     <= op_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    p_r      <= p_nxt;
    cnt_r    <= cnt_nxt;
    neg_r    <= neg_nxt;
    result_r <= result_nxt;
  end

  assign sts.busy = (state_r != U_IDLE);
  assign sts.done = done_r;
  assign result   = result_r;

endmodule

// ===== src/integer_accumulator_alu.sv =====
// integer accumulator alu
// input channel in_valid / in_stall / in_data carries a mode and an operand;
// each accepted word replaces the accumulator (DATA_WIDTH bits) with
// acc+b, acc-b, acc*b, acc/b, acc*acc, rounded sqrt(|acc|) or b (load)
// result channel out_valid / out_stall / out_data gives one word per input
// word: the new accumulator (low 32 bits) and a divide-by-zero flag
// one word at a time: in_stall is high from acceptance until write-back
// add, subtract, load, unused mode, divide by zero: result goes straight to write-back
// multiply and square: serial unit (one multiplier bit a cycle)
// divide: serial unit (one quotient bit a cycle)
// square root: serial unit (one root bit a cycle)
// the serial unit uses shift-add, restoring division and digit-by-digit root
// the output register lets the next word be accepted while a result waits;
// a finished result is held until the output register is free
// reset (rst_n low, synchronous) sets the accumulator to 2 and empties the
// output register
module integer_accumulator_alu import iacc_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  iacc_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output iacc_out_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_WB   = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic [DATA_WIDTH-1:0] acc_r, acc_nxt;
  logic [DATA_WIDTH-1:0] res_r, res_nxt;
  logic                  flag_r, flag_nxt;
  logic                  out_valid_r, out_valid_nxt;
  iacc_out_t             out_data_r, out_data_nxt;

  logic                  in_fire, wb_fire;
  logic [DATA_WIDTH-1:0] b_ext;
  iacc_cmd_t             cmd;
  iacc_sts_t             sts;
  logic [DATA_WIDTH-1:0] unit_a, unit_b, unit_res;

  assign in_fire = in_valid && !in_stall;
  assign wb_fire = (state_r == S_WB) && (!out_valid_r || !out_stall);
  assign b_ext   = DATA_WIDTH'(in_data.operand);

  iacc_serial_unit #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_serial (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .a     (unit_a),
    .b     (unit_b),
    .sts   (sts),
    .result(unit_res)
  );

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    res_nxt   = res_r;
    flag_nxt  = flag_r;
    cmd.start = 1'b0;
    cmd.op    = UOP_MUL;
    unit_a    = acc_r;
    unit_b    = b_ext;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          flag_nxt  = 1'b0;
          state_nxt = S_WB;
          case (in_data.mode)
            MODE_ADD:  res_nxt = acc_r + b_ext;
            MODE_SUB:  res_nxt = acc_r - b_ext;
            MODE_LOAD: res_nxt = b_ext;
            MODE_MUL: begin
              cmd.start = 1'b1;
              state_nxt = S_RUN;
            end
            MODE_SQUARE: begin
              unit_b    = acc_r;
              cmd.start = 1'b1;
              state_nxt = S_RUN;
            end
            MODE_DIV: begin
              if (b_ext == '0) begin
                flag_nxt = 1'b1;
                res_nxt  = acc_r;
              end else begin
                cmd.op    = UOP_DIV;
                cmd.start = 1'b1;
                state_nxt = S_RUN;
              end
            end
            MODE_SQRT: begin
              cmd.op    = UOP_SQRT;
              cmd.start = 1'b1;
              state_nxt = S_RUN;
            end
            default: res_nxt = acc_r;
          endcase
        end
      end
      S_RUN: begin
        if (sts.done) begin
          res_nxt   = unit_res;
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        if (wb_fire) begin
          acc_nxt   = res_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (wb_fire) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.value          = VALUE_W'(res_r);
      out_data_nxt.divide_by_zero = flag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= DATA_WIDTH'(2);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_r      <= res_nxt;
    flag_r     <= flag_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // an accepted word always leaves the idle state
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != S_IDLE))
    else $error("accepted word did not start processing");

  // the serial unit only reports completion while we wait for it
  assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> (state_r == S_RUN))
    else $error("serial unit finished outside run state");

  // divide by zero keeps the accumulator
  assert property (@(posedge clk) disable iff (!rst_n)
    (wb_fire && flag_r) |=> $stable(acc_r))
    else $error("accumulator changed on divide by zero");

  // the serial unit is never started while still busy
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !sts.busy)
    else $error("serial unit started while busy");

endmodule
